// File: src/hsd_pkg.sv
`default_nettype none

package hsd_pkg;

    // Fixed-point setup
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int SUM_WIDTH       = 32;
    localparam int GAIN_FRAC       = 8;
    localparam int PROD_SHIFT      = ANGLE_FRAC_BITS + GAIN_FRAC;

    // Field widths
    localparam int GAIN_W   = 16;
    localparam int TARGET_W = 15;
    localparam int ANGLE_W  = 16;
    localparam int DUTY_W   = 16;
    localparam int ERR_W    = 17;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int PID_W    = 17;

    // Product and accumulator widths (gain is zero-extended to a signed operand)
    localparam int P_W   = GAIN_W + 1 + ERR_W;
    localparam int I_W   = GAIN_W + 1 + SUM_WIDTH;
    localparam int D_W   = GAIN_W + 1 + DERIV_W;
    localparam int ACC_W = I_W + 2;
    localparam int Q_W   = ACC_W - PROD_SHIFT;

    // 180 degrees in angle units
    localparam int TARGET_MAX = 180 << ANGLE_FRAC_BITS;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // Port widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_FIELD_W = 2 * DUTY_W + PID_W + 1;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        MODE_PID  = 2'd0,
        MODE_FULL = 2'd1,
        MODE_RATE = 2'd2,
        MODE_HOLD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2,
        DIR_KEEP = 2'd3
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_TARGET     = 3'd3,
        REG_LIMIT      = 3'd4,
        REG_SWAP       = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [TARGET_W-1:0] setpoint;
        logic [DUTY_W-1:0]   drive_limit;
        logic                swap_channels;
    } cfg_t;

    // Per-word control carried down the pipe
    typedef struct packed {
        mode_t             mode;
        dir_t              dir;
        logic [DUTY_W-1:0] rate;
        logic              sat;
    } ctrl_t;

endpackage

`default_nettype wire

// File: src/hsd_integrator.sv
`default_nettype none

module hsd_integrator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  hsd_pkg::ctrl_t                        in_ctrl,
    input  logic        [hsd_pkg::ANGLE_W-1:0]    in_angle,
    input  hsd_pkg::cfg_t                         cfg,
    output hsd_pkg::ctrl_t                        ctrl_reg,
    output logic signed [hsd_pkg::ERR_W-1:0]      err_reg,
    output logic signed [hsd_pkg::SUM_WIDTH-1:0]  sum_reg,
    output logic signed [hsd_pkg::DERIV_W-1:0]    deriv_reg
);
    import hsd_pkg::*;

    localparam logic [TARGET_W-1:0] TGT_CLAMP = TARGET_W'(TARGET_MAX);

    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]     last_error_reg;

    logic        [TARGET_W-1:0]  tgt;
    logic signed [ERR_W-1:0]     err;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [DERIV_W-1:0]   deriv;
    logic                        is_pid;
    ctrl_t                       ctrl_next;

    assign tgt = ({17'd0, cfg.setpoint} > 32'(TARGET_MAX)) ? TGT_CLAMP : cfg.setpoint;
    assign err = $signed({2'b00, tgt}) - $signed({1'b0, in_angle});

    // saturating integral
    assign sum_wide = (SUM_WIDTH+1)'(error_sum_reg) + (SUM_WIDTH+1)'(err);

    always_comb begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end
    end

    assign deriv  = DERIV_W'(err) - DERIV_W'(last_error_reg);
    assign is_pid = (in_ctrl.mode == MODE_PID);

    always_comb begin
        ctrl_next = in_ctrl;
        if (is_pid) begin
            ctrl_next.sat = (sum_sat == SUM_MAX) || (sum_sat == SUM_MIN);
        end else begin
            ctrl_next.sat = (error_sum_reg == SUM_MAX) || (error_sum_reg == SUM_MIN);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end else if (load && is_pid) begin
            error_sum_reg  <= sum_sat;
            last_error_reg <= err;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ctrl_reg  <= ctrl_next;
            err_reg   <= err;
            sum_reg   <= sum_sat;
            deriv_reg <= deriv;
        end
    end

endmodule

`default_nettype wire

// File: src/hsd_products.sv
`default_nettype none

module hsd_products (
    input  logic                                  aclk,
    input  logic                                  load_mul,
    input  logic                                  load_sum,
    input  hsd_pkg::ctrl_t                        in_ctrl,
    input  logic signed [hsd_pkg::ERR_W-1:0]      in_err,
    input  logic signed [hsd_pkg::SUM_WIDTH-1:0]  in_sum,
    input  logic signed [hsd_pkg::DERIV_W-1:0]    in_deriv,
    input  hsd_pkg::cfg_t                         cfg,
    output hsd_pkg::ctrl_t                        ctrl_reg,
    output logic signed [hsd_pkg::ACC_W-1:0]      acc_reg
);
    import hsd_pkg::*;

    ctrl_t                mul_ctrl_reg;
    logic signed [P_W-1:0] p_reg;
    logic signed [I_W-1:0] i_reg;
    logic signed [D_W-1:0] d_reg;

    logic signed [P_W-1:0] p_next;
    logic signed [I_W-1:0] i_next;
    logic signed [D_W-1:0] d_next;
    logic signed [ACC_W-1:0] acc_next;

    assign p_next = $signed({1'b0, cfg.prop_gain})  * in_err;
    assign i_next = $signed({1'b0, cfg.integ_gain}) * in_sum;
    assign d_next = $signed({1'b0, cfg.deriv_gain}) * in_deriv;

    assign acc_next = ACC_W'(p_reg) + ACC_W'(i_reg) + ACC_W'(d_reg);

    always_ff @(posedge aclk) begin
        if (load_mul) begin
            mul_ctrl_reg <= in_ctrl;
            p_reg        <= p_next;
            i_reg        <= i_next;
            d_reg        <= d_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_sum) begin
            ctrl_reg <= mul_ctrl_reg;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: src/hsd_drive.sv
`default_nettype none

module hsd_drive (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  hsd_pkg::ctrl_t                      in_ctrl,
    input  logic signed [hsd_pkg::ACC_W-1:0]    in_acc,
    input  hsd_pkg::cfg_t                       cfg,
    output logic        [hsd_pkg::DUTY_W-1:0]   duty_a_reg,
    output logic        [hsd_pkg::DUTY_W-1:0]   duty_b_reg,
    output logic signed [hsd_pkg::PID_W-1:0]    pid_reg,
    output logic                                sat_reg
);
    import hsd_pkg::*;

    localparam logic signed [ACC_W-1:0] BIAS = ACC_W'((64'd1 << PROD_SHIFT) - 64'd1);

    logic signed [ACC_W-1:0] acc_b;
    logic signed [Q_W-1:0]   quo;
    logic signed [Q_W-1:0]   lim_q;
    logic signed [PID_W-1:0] lim_p;
    logic signed [PID_W-1:0] pid_c;
    logic signed [PID_W-1:0] pid_neg;
    logic [DUTY_W-1:0]       level;
    logic [DUTY_W-1:0]       fwd;
    logic [DUTY_W-1:0]       rev;
    logic                    write_duty;

    logic [DUTY_W-1:0]       duty_a_next;
    logic [DUTY_W-1:0]       duty_b_next;
    logic signed [PID_W-1:0] pid_next;

    // truncate toward zero: bias negatives before the arithmetic shift
    assign acc_b = in_acc + (in_acc[ACC_W-1] ? BIAS : '0);
    assign quo   = acc_b[ACC_W-1:PROD_SHIFT];
    assign lim_q = $signed(Q_W'({1'b0, cfg.drive_limit}));
    assign lim_p = $signed({1'b0, cfg.drive_limit});

    always_comb begin
        if (quo >= lim_q) begin
            pid_c = lim_p;
        end else if (quo <= -lim_q) begin
            pid_c = -lim_p;
        end else begin
            pid_c = quo[PID_W-1:0];
        end
    end

    assign pid_neg = -pid_c;
    assign level   = (in_ctrl.mode == MODE_FULL) ? cfg.drive_limit : in_ctrl.rate;

    always_comb begin
        fwd        = '0;
        rev        = '0;
        write_duty = 1'b1;
        pid_next   = pid_reg;
        unique case (in_ctrl.mode)
            MODE_PID: begin
                pid_next = pid_c;
                if (pid_c > 0) begin
                    fwd = pid_c[DUTY_W-1:0];
                end else begin
                    rev = pid_neg[DUTY_W-1:0];
                end
            end
            MODE_FULL, MODE_RATE: begin
                unique case (in_ctrl.dir)
                    DIR_STOP: ;
                    DIR_FWD:  fwd = level;
                    DIR_REV:  rev = level;
                    DIR_KEEP: write_duty = 1'b0;
                endcase
            end
            MODE_HOLD: write_duty = 1'b0;
        endcase
    end

    always_comb begin
        duty_a_next = duty_a_reg;
        duty_b_next = duty_b_reg;
        if (write_duty) begin
            duty_a_next = cfg.swap_channels ? rev : fwd;
            duty_b_next = cfg.swap_channels ? fwd : rev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_a_reg <= '0;
            duty_b_reg <= '0;
            pid_reg    <= '0;
            sat_reg    <= 1'b0;
        end else if (load) begin
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
            pid_reg    <= pid_next;
            sat_reg    <= in_ctrl.sat;
        end
    end

endmodule

`default_nettype wire

// File: src/pid_hbridge_servo_drive.sv
// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    s_tuser: mode; s_tdata: direction, angle, rate
// m_        out  m_tvalid / m_tready    m_tdata: duty_a, duty_b, pid_output, saturated
// cfg_      in   cfg_valid / cfg_ready  cfg_index: register, cfg_data: value
//
// One word per clock sustained while m_tready is high. Five-register pipe: input,
// integrator, multipliers, adder, result. A word shows on m_ once it reaches the
// result register. Integrator and last-error registers update as each PID-mode word
// loads the integrator stage, which is what lets back-to-back words follow each other.
// aresetn (sync) clears valids, integrator, last error, config, held duties and
// last PID output. Each stage moves when the one below has room; with m_tready low
// up to five words sit in the pipe before s_tready drops. cfg_ready is always high.
`default_nettype none

module pid_hbridge_servo_drive (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata, low bit up: direction[1:0], measured_angle[17:2], drive_rate[33:18]
    input  logic [hsd_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: mode[1:0]
    input  logic [hsd_pkg::S_TUSER_W-1:0]     s_tuser,
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata, low bit up: duty_a[15:0], duty_b[31:16], pid_output[48:32],
    // integral_saturated[49]
    output logic [hsd_pkg::M_TDATA_W-1:0]     m_tdata,
    // config write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hsd_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import hsd_pkg::*;

    localparam int NSTG = 5;

    // config registers
    cfg_t cfg_reg;
    cfg_t cfg_next;

    // stage valids and handshake
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] load;

    // input register
    ctrl_t              in_ctrl_reg;
    logic [ANGLE_W-1:0] in_angle_reg;
    ctrl_t              s_ctrl;

    // stage links
    ctrl_t                       int_ctrl;
    logic signed [ERR_W-1:0]     int_err;
    logic signed [SUM_WIDTH-1:0] int_sum;
    logic signed [DERIV_W-1:0]   int_deriv;
    ctrl_t                       acc_ctrl;
    logic signed [ACC_W-1:0]     acc;

    logic [DUTY_W-1:0]       duty_a;
    logic [DUTY_W-1:0]       duty_b;
    logic signed [PID_W-1:0] pid_out;
    logic                    sat;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_PROP_GAIN:  cfg_next.prop_gain     = cfg_data;
                REG_INTEG_GAIN: cfg_next.integ_gain    = cfg_data;
                REG_DERIV_GAIN: cfg_next.deriv_gain    = cfg_data;
                REG_TARGET:     cfg_next.setpoint      = cfg_data[TARGET_W-1:0];
                REG_LIMIT:      cfg_next.drive_limit   = cfg_data;
                REG_SWAP:       cfg_next.swap_channels = cfg_data[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- pipe control ----------------
    // stage k takes a word when it is empty or its word moves on
    always_comb begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG-2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        load[0]     = s_tvalid && rdy[0];
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            load[k]     = vld_reg[k-1] && rdy[k];
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];

    // ---------------- input register ----------------
    always_comb begin
        s_ctrl      = '0;
        s_ctrl.mode = mode_t'(s_tuser[1:0]);
        s_ctrl.dir  = dir_t'(s_tdata[1:0]);
        s_ctrl.rate = s_tdata[33:18];
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            in_ctrl_reg  <= s_ctrl;
            in_angle_reg <= s_tdata[17:2];
        end
    end

    // ---------------- datapath ----------------
    hsd_integrator u_integ (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load[1]),
        .in_ctrl   (in_ctrl_reg),
        .in_angle  (in_angle_reg),
        .cfg       (cfg_reg),
        .ctrl_reg  (int_ctrl),
        .err_reg   (int_err),
        .sum_reg   (int_sum),
        .deriv_reg (int_deriv)
    );

    hsd_products u_prod (
        .aclk     (aclk),
        .load_mul (load[2]),
        .load_sum (load[3]),
        .in_ctrl  (int_ctrl),
        .in_err   (int_err),
        .in_sum   (int_sum),
        .in_deriv (int_deriv),
        .cfg      (cfg_reg),
        .ctrl_reg (acc_ctrl),
        .acc_reg  (acc)
    );

    // result register doubles as the held duty / last PID output state
    hsd_drive u_drive (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load[4]),
        .in_ctrl    (acc_ctrl),
        .in_acc     (acc),
        .cfg        (cfg_reg),
        .duty_a_reg (duty_a),
        .duty_b_reg (duty_b),
        .pid_reg    (pid_out),
        .sat_reg    (sat)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, sat, pid_out, duty_b, duty_a};

endmodule

`default_nettype wire

// File: src/hsd_checker.sv
`default_nettype none

module hsd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hsd_pkg::M_TDATA_W-1:0] m_tdata
);
    import hsd_pkg::*;

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped under stall");

    // bridge never drives both channels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DUTY_W-1:0] == '0) || (m_tdata[2*DUTY_W-1:DUTY_W] == '0))
        else $error("both bridge channels driven");

    // input backs up only when the output side is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // reset empties the pipe
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipe not empty after reset");

endmodule

bind pid_hbridge_servo_drive hsd_checker u_hsd_checker (.*);

`default_nettype wire
